FILE: rtl/bes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bes_pkg
// Shared types and register map of the bilinear energy splat block.
// ----------------------------------------------------------------------------
package bes_pkg;

	// register indexes on the APB port (byte address = 4 * index)
	localparam logic [2:0] REG_ORIGIN_RANGE = 3'd0;
	localparam logic [2:0] REG_ORIGIN_TIME  = 3'd1;
	localparam logic [2:0] REG_RANGE_SCALE  = 3'd2;
	localparam logic [2:0] REG_TIME_SCALE   = 3'd3;
	localparam logic [2:0] REG_COLS_IN_USE  = 3'd4;
	localparam logic [2:0] REG_ROWS_IN_USE  = 3'd5;
	localparam logic [2:0] REG_EDGE_GUARD   = 3'd6;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_POS,
		ST_WA,
		ST_WB,
		ST_RMW,
		ST_RDP,
		ST_DONE
	} bes_state_t;

endpackage

FILE: rtl/bes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bes_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/bilinear_energy_splat_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_energy_splat_top
// Image of saturating energy accumulators; add items splat a point's energy
// bilinearly over four pixels, read items return one pixel.
// ----------------------------------------------------------------------------
//  channel  | handshake               | beat contents
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid / in_ready     | action, range_coord, time_coord,
//           |                         | energy, read_col, read_row
//  out      | out_valid / out_ready   | pixel_value, status
//  apb      | psel/penable/pready     | paddr, pwdata, prdata
//
//  Add: two mapping stages, two weight stages, four read-modify-write
//  steps on the pixel RAM, result. Read: one RAM read, result. An
//  out-of-image add skips the weight and RMW stages. The single RAM write
//  port sets the RMW count. After reset a clear sweep over all COLS*ROWS
//  addresses zeroes the RAM; in_ready is low meanwhile. One item at a time;
//  a finished result waits in the output register while the next is taken.
// ----------------------------------------------------------------------------
module bilinear_energy_splat_top
	import bes_pkg::*;
#(
	parameter int COLS      = 256,
	parameter int ROWS      = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] range_coord,
	input  logic signed [31:0] time_coord,
	input  logic signed [31:0] energy,
	input  logic [7:0]         read_col,
	input  logic [7:0]         read_row,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pixel_value,
	output logic               status,
	// config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int F     = FRAC_BITS;
	localparam int DEPTH = COLS * ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = $clog2(COLS);
	localparam int RB    = $clog2(ROWS);
	localparam int CSW   = ($clog2(COLS + 1) > 9) ? $clog2(COLS + 1) : 9;
	localparam int RSW   = ($clog2(ROWS + 1) > 9) ? $clog2(ROWS + 1) : 9;
	localparam int PW    = 65;    // exact 33x32 product width
	localparam int WW    = F + 1; // weight 1..2^F
	localparam int EPW   = 33 + WW + 1;

	// ---------------- configuration ----------------
	logic signed [31:0] origin_range_q, origin_time_q, range_scale_q, time_scale_q;
	logic [8:0]         cols_in_use_q, rows_in_use_q;
	logic [15:0]        edge_guard_q;
	logic               cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_range_q <= '0;
			origin_time_q  <= '0;
			range_scale_q  <= 32'sd1 <<< F;
			time_scale_q   <= 32'sd1 <<< F;
			cols_in_use_q  <= 9'd256;
			rows_in_use_q  <= 9'd256;
			edge_guard_q   <= 16'd17;
		end else if (cfg_we) begin
			unique case (paddr[4:2])
				REG_ORIGIN_RANGE: origin_range_q <= pwdata;
				REG_ORIGIN_TIME:  origin_time_q  <= pwdata;
				REG_RANGE_SCALE:  range_scale_q  <= pwdata;
				REG_TIME_SCALE:   time_scale_q   <= pwdata;
				REG_COLS_IN_USE:  cols_in_use_q  <= pwdata[8:0];
				REG_ROWS_IN_USE:  rows_in_use_q  <= pwdata[8:0];
				REG_EDGE_GUARD:   edge_guard_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_ORIGIN_RANGE: prdata = origin_range_q;
			REG_ORIGIN_TIME:  prdata = origin_time_q;
			REG_RANGE_SCALE:  prdata = range_scale_q;
			REG_TIME_SCALE:   prdata = time_scale_q;
			REG_COLS_IN_USE:  prdata = {23'd0, cols_in_use_q};
			REG_ROWS_IN_USE:  prdata = {23'd0, rows_in_use_q};
			REG_EDGE_GUARD:   prdata = {16'd0, edge_guard_q};
			default:          prdata = '0;
		endcase
	end

	// effective image size, clamped to 2..COLS / 2..ROWS
	logic [CSW-1:0] cols_eff;
	logic [RSW-1:0] rows_eff;

	always_comb begin
		if (cols_in_use_q < 9'd2) begin
			cols_eff = CSW'(2);
		end else if (CSW'(cols_in_use_q) > CSW'(COLS)) begin
			cols_eff = CSW'(COLS);
		end else begin
			cols_eff = CSW'(cols_in_use_q);
		end
		if (rows_in_use_q < 9'd2) begin
			rows_eff = RSW'(2);
		end else if (RSW'(rows_in_use_q) > RSW'(ROWS)) begin
			rows_eff = RSW'(ROWS);
		end else begin
			rows_eff = RSW'(rows_in_use_q);
		end
	end

	// ---------------- pixel memory ----------------
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	bes_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------- datapath registers ----------------
	bes_state_t state_q, state_d;
	logic [AW-1:0]      clr_addr_q;
	logic [1:0]         k_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [31:0] energy_q;
	logic               rd_ok_q;
	logic signed [48:0] phx_s1, plx_s1, phy_s1, ply_s1;
	logic [F-1:0]       fx_q, fy_q;
	logic [AW-1:0]      addr_q [4];
	logic [3:0]         pix_ok_q;
	logic signed [32:0] above_q, below_q, ul_q, ll_q;
	logic signed [31:0] res_val_q;
	logic               res_stat_q;
	logic signed [31:0] out_val_q;
	logic               out_stat_q, out_valid_q;

	// read item checks
	logic          rd_in_ok;
	logic [AW-1:0] rd_in_addr;

	assign rd_in_ok   = (CSW'(read_col) < cols_eff) && (RSW'(read_row) < rows_eff);
	assign rd_in_addr = AW'(AW'(read_row) * AW'(COLS)) + AW'(read_col);

	// position: sum partial products, floor shift, bounds
	logic signed [PW-1:0] prod_x, prod_y, pos_x, pos_y, xmax, ymax, guard;
	logic                 pos_ok;
	logic [CB-1:0]        lx;
	logic [RB-1:0]        ay;
	logic [AW-1:0]        base_addr;

	always_comb begin
		prod_x = {phx_s1, 16'd0} + {{16{plx_s1[48]}}, plx_s1};
		prod_y = {phy_s1, 16'd0} + {{16{ply_s1[48]}}, ply_s1};
		pos_x  = prod_x >>> F;
		pos_y  = prod_y >>> F;
		guard  = $signed({{(PW-16){1'b0}}, edge_guard_q});
		xmax   = $signed({{(PW-CSW-F){1'b0}}, cols_eff - CSW'(1), {F{1'b0}}}) - guard;
		ymax   = $signed({{(PW-RSW-F){1'b0}}, rows_eff - RSW'(1), {F{1'b0}}}) - guard;
		pos_ok = (pos_x >= guard) && (pos_x <= xmax) && (pos_y >= guard) && (pos_y <= ymax);
		lx     = pos_x[F+CB-1:F];
		ay     = pos_y[F+RB-1:F];
		base_addr = AW'(AW'(ay) * AW'(COLS)) + AW'(lx);
	end

	// weights
	logic [WW-1:0]       wx, wy;
	logic signed [EPW-1:0] prod_a, prod_ul, prod_ll;

	always_comb begin
		wx      = {1'b1, {F{1'b0}}} - {1'b0, fx_q};
		wy      = {1'b1, {F{1'b0}}} - {1'b0, fy_q};
		prod_a  = EPW'(energy_q) * $signed({1'b0, wy});
		prod_ul = EPW'(above_q) * $signed({1'b0, wx});
		prod_ll = EPW'(below_q) * $signed({1'b0, wx});
	end

	// accumulate with saturation
	logic signed [32:0] contrib;
	logic signed [33:0] acc_sum;
	logic [31:0]        acc_sat;

	always_comb begin
		unique case (k_q)
			2'd0: contrib = ul_q;
			2'd1: contrib = above_q - ul_q;
			2'd2: contrib = ll_q;
			2'd3: contrib = below_q - ll_q;
		endcase
		acc_sum = {{2{ram_rdata[31]}}, ram_rdata} + {contrib[32], contrib};
		if (acc_sum[33:31] == 3'b000 || acc_sum[33:31] == 3'b111) begin
			acc_sat = acc_sum[31:0];
		end else if (acc_sum[33]) begin
			acc_sat = 32'h8000_0000;
		end else begin
			acc_sat = 32'h7FFF_FFFF;
		end
	end

	logic slot_free;
	assign slot_free = !out_valid_q || out_ready;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q[k_q];
		ram_wdata = acc_sat;
		ram_raddr = addr_q[0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = rd_in_addr;
				if (in_valid) begin
					state_d = (action == ACT_READ) ? ST_RDP : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_POS;
			ST_POS: state_d = pos_ok ? ST_WA : ST_DONE;
			ST_WA:  state_d = ST_WB;
			ST_WB: begin
				ram_raddr = addr_q[0];
				state_d   = ST_RMW;
			end
			ST_RMW: begin
				// write pixel k while pixel k+1 is read; the four are distinct
				ram_we    = pix_ok_q[k_q];
				ram_raddr = addr_q[k_q + 2'd1];
				if (k_q == 2'd3) begin
					state_d = ST_DONE;
				end
			end
			ST_RDP: state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (state_q == ST_RMW) begin
				k_q <= k_q + 2'd1;
			end else begin
				k_q <= '0;
			end
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				dx_q     <= 33'(range_coord) - 33'(origin_range_q);
				dy_q     <= 33'(time_coord) - 33'(origin_time_q);
				energy_q <= energy;
				rd_ok_q  <= rd_in_ok;
			end
			ST_MUL: begin
				// 33x32 products as two 17x32 partial products each
				phx_s1 <= $signed(dx_q[32:16]) * 49'(range_scale_q);
				plx_s1 <= $signed({1'b0, dx_q[15:0]}) * 49'(range_scale_q);
				phy_s1 <= $signed(dy_q[32:16]) * 49'(time_scale_q);
				ply_s1 <= $signed({1'b0, dy_q[15:0]}) * 49'(time_scale_q);
			end
			ST_POS: begin
				fx_q      <= pos_x[F-1:0];
				fy_q      <= pos_y[F-1:0];
				addr_q[0] <= base_addr;
				addr_q[1] <= base_addr + AW'(1);
				addr_q[2] <= base_addr + AW'(COLS);
				addr_q[3] <= base_addr + AW'(COLS + 1);
				// neighbors past the last column or row get no write
				pix_ok_q[0] <= 1'b1;
				pix_ok_q[1] <= (CSW'(lx) + CSW'(1)) < cols_eff;
				pix_ok_q[2] <= (RSW'(ay) + RSW'(1)) < rows_eff;
				pix_ok_q[3] <= ((CSW'(lx) + CSW'(1)) < cols_eff)
					&& ((RSW'(ay) + RSW'(1)) < rows_eff);
				res_val_q  <= '0;
				res_stat_q <= !pos_ok;
			end
			ST_WA: begin
				above_q <= 33'(prod_a >>> F);
			end
			ST_WB: begin
				below_q <= 33'(energy_q) - above_q;
				ul_q    <= 33'(prod_ul >>> F);
				ll_q    <= 33'(EPW'(33'(energy_q) - above_q) * $signed({1'b0, wx}) >>> F);
			end
			ST_RDP: begin
				res_val_q  <= rd_ok_q ? ram_rdata : 32'd0;
				res_stat_q <= !rd_ok_q;
			end
			default: ;
		endcase
		if (state_q == ST_DONE && slot_free) begin
			out_val_q  <= res_val_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = out_val_q;
	assign status      = out_stat_q;

endmodule
